[hdl/i2ceep_pkg.sv]
// Shared types, codes and constants for the I2C EEPROM transfer sequencer.
package i2ceep_pkg;

    // Transfer buffer geometry
    localparam int BUFFER_BYTES = 16;
    localparam int POS_W        = $clog2(BUFFER_BYTES);
    localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

    // Field widths
    localparam int OP_W    = 3;
    localparam int LEN_W   = 5;
    localparam int IDX_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int DEV_W   = 7;
    localparam int CMD_W   = 11;
    localparam int ERR_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register byte addresses, decoded on the word address bit
    localparam logic [PADDR_W-1:0] ADDR_DEVICE = 3'd0;

    // Control word bits toward the byte controller
    localparam logic [CMD_W-1:0] CMD_WE    = 11'h400;
    localparam logic [CMD_W-1:0] CMD_START = 11'h200;
    localparam logic [CMD_W-1:0] CMD_STOP  = 11'h100;

    localparam logic [DEV_W-1:0] DEVICE_RESET = 7'h10;

    typedef enum logic [OP_W-1:0] {
        OP_START_READ  = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_LOAD_BYTE   = 3'd2,
        OP_INTERRUPT   = 3'd3,
        OP_READ_BACK   = 3'd4
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 2'd0,
        ERR_BUSY       = 2'd1,
        ERR_NO_ACK     = 2'd2,
        ERR_UNEXPECTED = 2'd3
    } err_t;

    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_RD_MEMADDR = 9'b000000010,
        ST_RD_READDR  = 9'b000000100,
        ST_RD_DATA    = 9'b000001000,
        ST_RD_STORE   = 9'b000010000,
        ST_WR_DEVADDR = 9'b000100000,
        ST_WR_MEMADDR = 9'b001000000,
        ST_WR_DATA    = 9'b010000000,
        ST_WR_FINISH  = 9'b100000000
    } state_t;

    // One result of a transaction
    typedef struct packed {
        logic              cmd_valid;
        logic [CMD_W-1:0]  cmd_word;
        logic              done;
        err_t              err;
        logic [BYTE_W-1:0] rdata;
    } result_t;

    // Build the addressing control word: start with device address and R/W bit
    function automatic logic [CMD_W-1:0] addr_word(input logic [DEV_W-1:0] dev,
                                                   input logic rd);
        addr_word = CMD_WE | CMD_START | {3'b000, dev, rd};
    endfunction

    // Saturate a requested length to the buffer size
    function automatic logic [COUNT_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        if ({{(32-LEN_W){1'b0}}, len} > BUFFER_BYTES)
            clamp_len = COUNT_W'(BUFFER_BYTES);
        else
            clamp_len = COUNT_W'(len);
    endfunction

endpackage

[hdl/i2c_eeprom_transfer_sequencer.sv]
// I2C EEPROM transfer sequencer: a single state update per transaction.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per transaction:
//   start read, start write, load write byte, controller interrupt event, or
//   read back byte. Every accepted transaction yields exactly one result on
//   the output channel (out_valid/out_ready): the next control word for the
//   byte controller, done, an error code and a read-back byte.
//   The result is registered: it goes to the output register at acceptance,
//   or to the skid register while the receiver stalls. Throughput is one
//   transaction per cycle while the skid register is empty, set by the single state update done at acceptance.
//   When the receiver stalls, the output register holds and one more result
//   lands in a skid register; in_ready drops only while the skid is full.
//   The APB port sets the 7-bit device address at byte address 0; pready is
//   always high. Write it only while no transaction is in flight.
//   Reset returns the sequencer to idle, clears positions and counts, sets
//   the device address to 0x10 and empties the output stages. The byte
//   buffers are not cleared and hold no data until written.
module i2c_eeprom_transfer_sequencer
    import i2ceep_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Input channel
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    operation,
    input  logic [LEN_W-1:0]   length,
    input  logic [IDX_W-1:0]   index,
    input  logic [BYTE_W-1:0]  write_data,
    input  logic               status_busy,
    input  logic               status_ack,
    input  logic [BYTE_W-1:0]  status_byte,
    // Output channel
    output logic               out_valid,
    input  logic               out_ready,
    output logic               command_valid,
    output logic [CMD_W-1:0]   command_word,
    output logic               done_res,
    output logic [ERR_W-1:0]   error_code,
    output logic [BYTE_W-1:0]  read_data
);

    // Configuration
    logic [DEV_W-1:0]   device_reg;
    logic               cfg_write;

    // Sequencer state
    state_t             state_reg, state_next;
    logic [POS_W-1:0]   read_pos_reg, read_pos_next;
    logic [COUNT_W-1:0] read_count_reg, read_count_next;
    logic [POS_W-1:0]   write_pos_reg, write_pos_next;
    logic [COUNT_W-1:0] write_count_reg, write_count_next;

    // Byte buffers
    logic [BYTE_W-1:0]  read_buf_reg [BUFFER_BYTES];
    logic [BYTE_W-1:0]  write_buf_reg [BUFFER_BYTES];
    logic               rbuf_we;
    logic               wbuf_we;

    // Output stages
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;
    logic               skid_valid_reg, skid_valid_next;
    result_t            skid_data_reg, skid_data_next;

    logic               accept;
    result_t            res;

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_DEVICE[2]);
    assign prdata    = (paddr[2] == ADDR_DEVICE[2]) ?
                       {{(PDATA_W-DEV_W){1'b0}}, device_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_reg <= DEVICE_RESET;
        end
        else if (cfg_write)
        begin
            device_reg <= pwdata[DEV_W-1:0];
        end
    end

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;

    // Decode the transaction and advance the sequence
    always_comb
    begin
        state_next       = state_reg;
        read_pos_next    = read_pos_reg;
        read_count_next  = read_count_reg;
        write_pos_next   = write_pos_reg;
        write_count_next = write_count_reg;
        rbuf_we          = 1'b0;
        wbuf_we          = 1'b0;
        res              = '0;
        res.err          = ERR_NONE;

        if (accept)
        begin
            case (op_t'(operation))
                OP_START_READ:
                begin
                    read_count_next = clamp_len(length);
                    read_pos_next   = '0;
                    res.cmd_valid   = 1'b1;
                    res.cmd_word    = addr_word(device_reg, 1'b0);
                    state_next      = ST_RD_MEMADDR;
                end
                OP_START_WRITE:
                begin
                    write_count_next = clamp_len(length);
                    write_pos_next   = '0;
                    res.cmd_valid    = 1'b1;
                    res.cmd_word     = addr_word(device_reg, 1'b0);
                    state_next       = ST_WR_MEMADDR;
                end
                OP_LOAD_BYTE:
                begin
                    wbuf_we = 1'b1;
                end
                OP_INTERRUPT:
                begin
                    if (status_busy)
                    begin
                        res.err    = ERR_BUSY;
                        state_next = ST_IDLE;
                    end
                    else if (!status_ack)
                    begin
                        res.err    = ERR_NO_ACK;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        case (state_reg)
                            ST_RD_MEMADDR:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = CMD_WE | {{(CMD_W-POS_W){1'b0}}, read_pos_reg};
                                state_next    = ST_RD_READDR;
                            end
                            ST_RD_READDR:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = addr_word(device_reg, 1'b1);
                                state_next    = ST_RD_DATA;
                            end
                            ST_RD_DATA:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = CMD_STOP;
                                state_next    = ST_RD_STORE;
                            end
                            ST_RD_STORE:
                            begin
                                rbuf_we = 1'b1;
                                if ((COUNT_W'(read_pos_reg) + COUNT_W'(1)) < read_count_reg)
                                begin
                                    read_pos_next = read_pos_reg + POS_W'(1);
                                    res.cmd_valid = 1'b1;
                                    res.cmd_word  = addr_word(device_reg, 1'b0);
                                    state_next    = ST_RD_MEMADDR;
                                end
                                else
                                begin
                                    res.done   = 1'b1;
                                    state_next = ST_IDLE;
                                end
                            end
                            ST_WR_DEVADDR:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = addr_word(device_reg, 1'b0);
                                state_next    = ST_WR_MEMADDR;
                            end
                            ST_WR_MEMADDR:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = CMD_WE | {{(CMD_W-POS_W){1'b0}}, write_pos_reg};
                                state_next    = ST_WR_DATA;
                            end
                            ST_WR_DATA:
                            begin
                                res.cmd_valid = 1'b1;
                                res.cmd_word  = CMD_WE | CMD_STOP |
                                                {3'b000, write_buf_reg[write_pos_reg]};
                                if ((COUNT_W'(write_pos_reg) + COUNT_W'(1)) < write_count_reg)
                                begin
                                    write_pos_next = write_pos_reg + POS_W'(1);
                                    state_next     = ST_WR_DEVADDR;
                                end
                                else
                                begin
                                    state_next = ST_WR_FINISH;
                                end
                            end
                            ST_WR_FINISH:
                            begin
                                res.done   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            ST_IDLE:
                            begin
                                res.err    = ERR_UNEXPECTED;
                                state_next = ST_IDLE;
                            end
                            default:
                            begin
                                res.err    = ERR_UNEXPECTED;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end
                end
                OP_READ_BACK:
                begin
                    res.rdata = read_buf_reg[index];
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    // Steer results into the output register or the skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            read_pos_reg    <= '0;
            read_count_reg  <= '0;
            write_pos_reg   <= '0;
            write_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            read_pos_reg    <= read_pos_next;
            read_count_reg  <= read_count_next;
            write_pos_reg   <= write_pos_next;
            write_count_reg <= write_count_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    // Payload and buffers
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (rbuf_we)
        begin
            read_buf_reg[read_pos_reg] <= status_byte;
        end
        if (wbuf_we)
        begin
            write_buf_reg[index] <= write_data;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_valid = out_data_reg.cmd_valid;
    assign command_word  = out_data_reg.cmd_word;
    assign done_res      = out_data_reg.done;
    assign error_code    = out_data_reg.err;
    assign read_data     = out_data_reg.rdata;

endmodule

[hdl/i2ceep_checker.sv]
// Port-level checks for the I2C EEPROM transfer sequencer, bound to the top level.
module i2ceep_checker
    import i2ceep_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               command_valid,
    input logic [CMD_W-1:0]   command_word,
    input logic               done_res,
    input logic [ERR_W-1:0]   error_code,
    input logic [BYTE_W-1:0]  read_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(command_word)
                                    && $stable(error_code) && $stable(read_data))
    else $error("stalled result changed");

    // Drop the control word when no command is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !command_valid |-> command_word == '0)
    else $error("control word without command");

    // Abort a run on error: no command, no done
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != ERR_NONE |-> !command_valid && !done_res)
    else $error("error result carries a command or done");

    // Finish a run without issuing a further command or carrying a read-back byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !command_valid && read_data == '0)
    else $error("done result carries a command");

    // Keep the configuration port always ready
    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind i2c_eeprom_transfer_sequencer i2ceep_checker u_checker (.*);
